// ===== rtl/i2cms_pkg.sv =====
// i2cms_pkg: shared types and codes for the I2C master register sequencer.
// No dependencies; imported by the front, back and top-level modules.
package i2cms_pkg;

   typedef enum logic [1:0] {
      OP_QUEUE = 2'd0,
      OP_DONE  = 2'd1,
      OP_PUSH  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_START  = 3'd1;
   localparam logic [2:0] ACT_TX     = 3'd2;
   localparam logic [2:0] ACT_RSTART = 3'd3;
   localparam logic [2:0] ACT_RCV    = 3'd4;
   localparam logic [2:0] ACT_ACKBIT = 3'd5;
   localparam logic [2:0] ACT_STOP   = 3'd6;

   localparam int REQ_BITS = 24;

   typedef struct packed {
      logic       rd;
      logic [6:0] addr;
      logic [7:0] sub;
      logic [7:0] len;
   } req_entry_type;

   typedef struct packed {
      op_type        op;
      req_entry_type req;
      logic [7:0]    data;
   } cmd_type;

   typedef struct packed {
      logic [2:0] bus_action;
      logic [7:0] tx_byte;
      logic       ack_level;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       transaction_done;
      logic       done_was_read;
      logic       request_rejected;
      logic       data_underrun;
      logic       bus_idle;
   } rsp_type;

endpackage

// ===== rtl/i2cms_ram.sv =====
// i2cms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/i2cms_front.sv =====
// i2cms_front: accepts requests, classifies the operation and holds them
// in a two-entry command queue. Depends on i2cms_pkg.
module i2cms_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic [6:0]        req_device_address,
   input  logic [7:0]        req_sub_address,
   input  logic              req_is_read,
   input  logic [7:0]        req_length,
   input  logic [7:0]        req_rx_byte,
   input  logic [7:0]        req_write_byte,
   output logic              cmd_valid,
   output i2cms_pkg::cmd_type cmd,
   input  logic              cmd_ready
);
   import i2cms_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    new_cmd;
   logic       push, pop;

   always_comb begin
      new_cmd.op       = op_type'(req_operation);
      new_cmd.req.rd   = req_is_read;
      new_cmd.req.addr = req_device_address;
      new_cmd.req.sub  = req_sub_address;
      new_cmd.req.len  = req_length;
      new_cmd.data     = (new_cmd.op == OP_DONE) ? req_rx_byte : req_write_byte;
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/i2cms_back.sv =====
// i2cms_back: request queue, write-data FIFO and bus sequencing state; runs
// one command per pass and registers the result. Depends on i2cms_pkg, i2cms_ram.
module i2cms_back #(
   parameter int REQ_DEPTH   = 8,
   parameter int WDATA_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  i2cms_pkg::cmd_type cmd,
   output logic               cmd_ready,
   output logic               rsp_valid,
   output i2cms_pkg::rsp_type rsp,
   input  logic               rsp_ready
);
   import i2cms_pkg::*;

   localparam int RA = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
   localparam int RC = $clog2(REQ_DEPTH + 1);
   localparam int WA = (WDATA_DEPTH > 1) ? $clog2(WDATA_DEPTH) : 1;
   localparam int WC = $clog2(WDATA_DEPTH + 1);

   typedef enum logic [1:0] {PH_IDLE, PH_READ, PH_EXEC} phase_type;
   typedef enum logic [3:0] {
      S_STOPPED, S_STARTED, S_ADDR_W, S_SUB, S_DATA_TX,
      S_RESTART, S_ADDR_R, S_DATA_RX, S_ACK, S_NACK
   } seq_type;

   phase_type     phase_ff, phase_in;
   seq_type       seq_ff, seq_in;
   cmd_type       cmd_ff, cmd_in;
   logic          rej_ff, rej_in;
   req_entry_type active_ff, active_in;
   logic [7:0]    byte_idx_ff, byte_idx_in;
   logic          idle_ff, idle_in;
   logic [RA-1:0] req_head_ff, req_head_in;
   logic [RC-1:0] req_count_ff, req_count_in;
   logic [WA-1:0] wf_head_ff, wf_head_in;
   logic [WC-1:0] wf_count_ff, wf_count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          req_we, wf_we;
   logic [RA:0]   req_sum;
   logic [RA-1:0] req_tail;
   logic [WA:0]   wf_sum;
   logic [WA-1:0] wf_tail;
   logic [REQ_BITS-1:0] req_rdata;
   logic [7:0]    wf_rdata;
   logic          exec_fire, adv, need_byte;
   logic [7:0]    idx_next;
   rsp_type       res;

   always_comb begin
      req_sum  = {1'b0, req_head_ff} + (RA+1)'(req_count_ff);
      req_tail = (req_sum >= (RA+1)'(REQ_DEPTH)) ? RA'(req_sum - (RA+1)'(REQ_DEPTH))
                                                  : RA'(req_sum);
      wf_sum   = {1'b0, wf_head_ff} + (WA+1)'(wf_count_ff);
      wf_tail  = (wf_sum >= (WA+1)'(WDATA_DEPTH)) ? WA'(wf_sum - (WA+1)'(WDATA_DEPTH))
                                                   : WA'(wf_sum);
   end

   i2cms_ram #(.WIDTH(REQ_BITS), .DEPTH(REQ_DEPTH)) u_req_ram (
      .clock (clock),
      .we    (req_we),
      .waddr (req_tail),
      .wdata (cmd.req),
      .raddr (req_head_ff),
      .rdata (req_rdata)
   );

   i2cms_ram #(.WIDTH(8), .DEPTH(WDATA_DEPTH)) u_wdata_ram (
      .clock (clock),
      .we    (wf_we),
      .waddr (wf_tail),
      .wdata (cmd.data),
      .raddr (wf_head_ff),
      .rdata (wf_rdata)
   );

   assign cmd_ready = (phase_ff == PH_IDLE);
   assign exec_fire = (phase_ff == PH_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign idx_next  = byte_idx_ff + 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      seq_in       = seq_ff;
      cmd_in       = cmd_ff;
      rej_in       = rej_ff;
      active_in    = active_ff;
      byte_idx_in  = byte_idx_ff;
      idle_in      = idle_ff;
      req_head_in  = req_head_ff;
      req_count_in = req_count_ff;
      wf_head_in   = wf_head_ff;
      wf_count_in  = wf_count_ff;
      rsp_in       = rsp_ff;
      req_we       = 1'b0;
      wf_we        = 1'b0;
      adv          = 1'b0;
      need_byte    = 1'b0;
      res          = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               rej_in   = 1'b0;
               phase_in = PH_READ;
               if (cmd.op == OP_QUEUE) begin
                  if (req_count_ff == RC'(REQ_DEPTH)) begin
                     rej_in = 1'b1;
                  end else begin
                     req_we       = 1'b1;
                     req_count_in = req_count_ff + RC'(1);
                  end
               end else if (cmd.op == OP_PUSH) begin
                  if (wf_count_ff == WC'(WDATA_DEPTH)) begin
                     rej_in = 1'b1;
                  end else begin
                     wf_we       = 1'b1;
                     wf_count_in = wf_count_ff + WC'(1);
                  end
               end
            end
         end
         PH_READ: begin
            phase_in = PH_EXEC;
         end
         PH_EXEC: begin
            if (exec_fire) begin
               phase_in = PH_IDLE;
               if (cmd_ff.op inside {OP_QUEUE, OP_PUSH}) begin
                  res.request_rejected = rej_ff;
               end
               adv = (cmd_ff.op == OP_DONE) || (cmd_ff.op == OP_QUEUE && idle_ff);
               if (adv) begin
                  case ((cmd_ff.op == OP_QUEUE) ? S_STOPPED : seq_ff)
                     S_STARTED: begin
                        res.bus_action = ACT_TX;
                        res.tx_byte    = {active_ff.addr, 1'b0};
                        byte_idx_in    = 8'd0;
                        seq_in         = S_ADDR_W;
                     end
                     S_ADDR_W: begin
                        res.bus_action = ACT_TX;
                        res.tx_byte    = active_ff.sub;
                        seq_in         = S_SUB;
                     end
                     S_SUB: begin
                        if (active_ff.rd) begin
                           res.bus_action = ACT_RSTART;
                           seq_in         = S_RESTART;
                        end else begin
                           res.bus_action = ACT_TX;
                           need_byte      = 1'b1;
                           seq_in         = S_DATA_TX;
                        end
                     end
                     S_DATA_TX: begin
                        byte_idx_in = idx_next;
                        if (idx_next == active_ff.len) begin
                           res.bus_action       = ACT_STOP;
                           res.transaction_done = 1'b1;
                           seq_in               = S_STOPPED;
                        end else begin
                           res.bus_action = ACT_TX;
                           need_byte      = 1'b1;
                        end
                     end
                     S_RESTART: begin
                        res.bus_action = ACT_TX;
                        res.tx_byte    = {active_ff.addr, 1'b1};
                        seq_in         = S_ADDR_R;
                     end
                     S_ADDR_R, S_ACK: begin
                        res.bus_action = ACT_RCV;
                        seq_in         = S_DATA_RX;
                     end
                     S_DATA_RX: begin
                        res.rx_valid   = 1'b1;
                        res.rx_data    = cmd_ff.data;
                        res.bus_action = ACT_ACKBIT;
                        byte_idx_in    = idx_next;
                        if (idx_next == active_ff.len) begin
                           res.ack_level = 1'b1;
                           seq_in        = S_NACK;
                        end else begin
                           seq_in = S_ACK;
                        end
                     end
                     S_NACK: begin
                        res.bus_action       = ACT_STOP;
                        res.transaction_done = 1'b1;
                        res.done_was_read    = 1'b1;
                        seq_in               = S_STOPPED;
                     end
                     default: begin
                        if (req_count_in == '0) begin
                           idle_in = 1'b1;
                           seq_in  = S_STOPPED;
                        end else begin
                           active_in    = req_entry_type'(req_rdata);
                           req_head_in  = (req_head_ff == RA'(REQ_DEPTH - 1)) ? '0
                                                                             : req_head_ff + RA'(1);
                           req_count_in = req_count_ff - RC'(1);
                           res.bus_action = ACT_START;
                           idle_in      = 1'b0;
                           seq_in       = S_STARTED;
                        end
                     end
                  endcase
               end
               if (need_byte) begin
                  if (wf_count_ff == '0) begin
                     res.data_underrun = 1'b1;
                  end else begin
                     res.tx_byte = wf_rdata;
                     wf_head_in  = (wf_head_ff == WA'(WDATA_DEPTH - 1)) ? '0
                                                                      : wf_head_ff + WA'(1);
                     wf_count_in = wf_count_ff - WC'(1);
                  end
               end
               res.bus_idle = idle_in && (req_count_in == '0);
               rsp_in       = res;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      rsp_valid_in = exec_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         seq_ff       <= S_STOPPED;
         active_ff    <= '0;
         byte_idx_ff  <= 8'd0;
         idle_ff      <= 1'b1;
         req_head_ff  <= '0;
         req_count_ff <= '0;
         wf_head_ff   <= '0;
         wf_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         active_ff    <= active_in;
         byte_idx_ff  <= byte_idx_in;
         idle_ff      <= idle_in;
         req_head_ff  <= req_head_in;
         req_count_ff <= req_count_in;
         wf_head_ff   <= wf_head_in;
         wf_count_ff  <= wf_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      rej_ff <= rej_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== rtl/i2c_master_register_sequencer_top.sv =====
// i2c_master_register_sequencer_top: I2C master register read/write sequencer.
// A request goes from the front queue through the back end's write, read and
// execute passes around the registered-read request and write-data RAMs; the
// back end takes no new request until it is done with the last one.
// Reset: synchronous; all queues empty, sequencer stopped, bus idle.
// Depends on i2cms_pkg, i2cms_front, i2cms_back, i2cms_ram.
module i2c_master_register_sequencer_top #(
   parameter int REQ_DEPTH   = 8,
   parameter int WDATA_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [6:0] req_device_address,
   input  logic [7:0] req_sub_address,
   input  logic       req_is_read,
   input  logic [7:0] req_length,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_write_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_bus_action,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_ack_level,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_data,
   output logic       rsp_transaction_done,
   output logic       rsp_done_was_read,
   output logic       rsp_request_rejected,
   output logic       rsp_data_underrun,
   output logic       rsp_bus_idle
);
   import i2cms_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;
   rsp_type rsp;

   i2cms_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_device_address (req_device_address),
      .req_sub_address    (req_sub_address),
      .req_is_read        (req_is_read),
      .req_length         (req_length),
      .req_rx_byte        (req_rx_byte),
      .req_write_byte     (req_write_byte),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_ready          (cmd_ready)
   );

   i2cms_back #(
      .REQ_DEPTH   (REQ_DEPTH),
      .WDATA_DEPTH (WDATA_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_ready (rsp_ready)
   );

   assign rsp_bus_action       = rsp.bus_action;
   assign rsp_tx_byte          = rsp.tx_byte;
   assign rsp_ack_level        = rsp.ack_level;
   assign rsp_rx_valid         = rsp.rx_valid;
   assign rsp_rx_data          = rsp.rx_data;
   assign rsp_transaction_done = rsp.transaction_done;
   assign rsp_done_was_read    = rsp.done_was_read;
   assign rsp_request_rejected = rsp.request_rejected;
   assign rsp_data_underrun    = rsp.data_underrun;
   assign rsp_bus_idle         = rsp.bus_idle;

endmodule
